// ===== hdl/tsf_pkg.sv =====
// Shared constants, register indexes and types of the touch sample filter.
package tsf_pkg;

	localparam int AVG_DEPTH_DEF   = 8;
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int EXT_W           = 12;
	localparam int CFG_IDX_W       = 3;

	localparam logic [CFG_IDX_W-1:0] REG_X_LOWER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_UPPER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LOWER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_UPPER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_EXTENT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_EXTENT = 3'd5;

	localparam int X_LOWER_RST  = 120;
	localparam int X_UPPER_RST  = 875;
	localparam int Y_LOWER_RST  = 120;
	localparam int Y_UPPER_RST  = 925;
	localparam int X_EXTENT_RST = 320;
	localparam int Y_EXTENT_RST = 480;

	typedef struct packed {
		logic rd;
		logic upd;
	} hist_cmd_t;

endpackage

// ===== hdl/tsf_hist.sv =====
// Sample history memory, running totals, settle count and touch status.
module tsf_hist #(
	parameter int AVG_DEPTH   = tsf_pkg::AVG_DEPTH_DEF,
	parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  tsf_pkg::hist_cmd_t                           cmd,
	input  logic [SAMPLE_BITS-1:0]                       sample,
	input  logic [SAMPLE_BITS-1:0]                       x_lower,
	input  logic [SAMPLE_BITS-1:0]                       x_upper,
	input  logic [SAMPLE_BITS-1:0]                       y_lower,
	input  logic [SAMPLE_BITS-1:0]                       y_upper,
	output logic [SAMPLE_BITS+$clog2(AVG_DEPTH)-1:0]     x_total,
	output logic [SAMPLE_BITS+$clog2(AVG_DEPTH)-1:0]     y_total,
	output logic                                         touched,
	output logic                                         y_phase
);
	import tsf_pkg::*;

	localparam int SLOT_W    = $clog2(AVG_DEPTH);
	localparam int TOT_W     = SAMPLE_BITS + SLOT_W;
	localparam int ADDR_W    = SLOT_W + 1;
	localparam int MEM_DEPTH = 2 ** ADDR_W;
	localparam int SET_W     = $clog2(AVG_DEPTH + 1);

	logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]   valid_q;
	logic [SAMPLE_BITS-1:0] samp_q;
	logic [SAMPLE_BITS-1:0] rdata_q;
	logic                   rvalid_q;
	logic [SLOT_W-1:0]      slot_q;
	logic                   next_x_q;
	logic [SET_W-1:0]       settle_q;
	logic                   touch_q;
	logic [TOT_W-1:0]       xt_q;
	logic [TOT_W-1:0]       yt_q;

	logic [ADDR_W-1:0]      addr;
	logic [SAMPLE_BITS-1:0] lo;
	logic [SAMPLE_BITS-1:0] hi;
	logic                   in_win;
	logic [SAMPLE_BITS-1:0] kept;
	logic [SAMPLE_BITS-1:0] old;
	logic [TOT_W-1:0]       total_cur;
	logic [TOT_W-1:0]       total_new;
	logic [SET_W-1:0]       settle_inc;
	logic                   slot_last;

	// X and Y histories share one memory, the axis forming the top address bit.
	assign addr       = {~next_x_q, slot_q};
	assign lo         = next_x_q ? x_lower : y_lower;
	assign hi         = next_x_q ? x_upper : y_upper;
	assign in_win     = (samp_q >= lo) && (samp_q <= hi);
	assign kept       = in_win ? samp_q : lo;
	assign old        = rvalid_q ? rdata_q : '0;
	assign total_cur  = next_x_q ? xt_q : yt_q;
	assign total_new  = total_cur - TOT_W'(old) + TOT_W'(kept);
	assign settle_inc = settle_q + 1'b1;
	assign slot_last  = (slot_q == SLOT_W'(AVG_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			samp_q   <= sample;
			rdata_q  <= mem[addr];
			rvalid_q <= valid_q[addr];
		end
		if (cmd.upd) begin
			mem[addr] <= kept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			slot_q   <= '0;
			next_x_q <= 1'b1;
			settle_q <= '0;
			touch_q  <= 1'b0;
			xt_q     <= '0;
			yt_q     <= '0;
		end else if (cmd.upd) begin
			valid_q[addr] <= 1'b1;
			next_x_q      <= ~next_x_q;
			if (next_x_q) begin
				xt_q <= total_new;
				if (!in_win) begin
					settle_q <= '0;
					touch_q  <= 1'b0;
				end else if (settle_inc == SET_W'(AVG_DEPTH)) begin
					settle_q <= '0;
					touch_q  <= 1'b1;
				end else begin
					settle_q <= settle_inc;
				end
			end else begin
				yt_q <= total_new;
				if (!in_win) begin
					touch_q <= 1'b0;
				end
				slot_q <= slot_last ? '0 : slot_q + 1'b1;
			end
		end
	end

	assign x_total = xt_q;
	assign y_total = yt_q;
	assign touched = touch_q;
	assign y_phase = ~next_x_q;

endmodule

// ===== hdl/tsf_map.sv =====
// Bit-serial averaging, scaling and division of one axis onto the screen.
module tsf_map #(
	parameter int AVG_DEPTH   = tsf_pkg::AVG_DEPTH_DEF,
	parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [SAMPLE_BITS+$clog2(AVG_DEPTH)-1:0] total,
	input  logic [SAMPLE_BITS-1:0]                   lower,
	input  logic [SAMPLE_BITS-1:0]                   upper,
	input  logic [tsf_pkg::EXT_W-1:0]                extent,
	output logic [tsf_pkg::EXT_W-1:0]                result,
	output logic                                     done
);
	import tsf_pkg::*;

	localparam int TOT_W  = SAMPLE_BITS + $clog2(AVG_DEPTH);
	localparam int DIV_W  = $clog2(AVG_DEPTH) + 1;
	localparam int PROD_W = SAMPLE_BITS + EXT_W;
	localparam int MAX_W  = (TOT_W > EXT_W) ? TOT_W : EXT_W;
	localparam int CNT_W  = $clog2(MAX_W);

	localparam logic [DIV_W-1:0] DEPTH_V = DIV_W'(AVG_DEPTH);

	localparam logic [2:0] L_IDLE  = 3'd0;
	localparam logic [2:0] L_AVG   = 3'd1;
	localparam logic [2:0] L_SETUP = 3'd2;
	localparam logic [2:0] L_MUL   = 3'd3;
	localparam logic [2:0] L_SAT   = 3'd4;
	localparam logic [2:0] L_DIV   = 3'd5;
	localparam logic [2:0] L_DONE  = 3'd6;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [TOT_W-1:0]       num_q;
	logic [DIV_W-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0] diff_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [EXT_W-1:0]       ext_q;
	logic [PROD_W-1:0]      acc_q;
	logic [SAMPLE_BITS-1:0] rdv_q;
	logic [EXT_W-1:0]       result_q;

	logic [DIV_W-1:0]       rem_sh;
	logic                   avg_ge;
	logic [DIV_W-1:0]       rem_nx;
	logic [SAMPLE_BITS-1:0] avg;
	logic                   early_zero;
	logic [PROD_W-1:0]      addend;
	logic [PROD_W-1:0]      acc_nx;
	logic                   sat;
	logic [SAMPLE_BITS:0]   div_sh;
	logic                   div_ge;
	logic [SAMPLE_BITS:0]   div_nx;

	// Restoring division by the averaging depth, one quotient bit a cycle;
	// the quotient shifts into num_q behind the dividend bits.
	assign rem_sh = {rem_q[DIV_W-2:0], num_q[TOT_W-1]};
	assign avg_ge = (rem_sh >= DEPTH_V);
	assign rem_nx = avg_ge ? rem_sh - DEPTH_V : rem_sh;
	assign avg    = num_q[SAMPLE_BITS-1:0];

	assign early_zero = (upper <= lower) || (avg < lower);

	// Shift-and-add multiply, extent bits taken from the top.
	assign addend = ext_q[EXT_W-1] ? PROD_W'(diff_q) : '0;
	assign acc_nx = {acc_q[PROD_W-2:0], 1'b0} + addend;

	// The quotient exceeds the screen range exactly when the product reaches
	// the span shifted up by the result width.
	assign sat = (acc_q >= {den_q, {EXT_W{1'b0}}});

	assign div_sh = {rdv_q, ext_q[EXT_W-1]};
	assign div_ge = (div_sh >= {1'b0, den_q});
	assign div_nx = div_ge ? div_sh - {1'b0, den_q} : div_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				L_IDLE, L_DONE: begin
					if (start) begin
						state_q <= L_AVG;
						cnt_q   <= CNT_W'(TOT_W - 1);
					end
				end
				L_AVG: begin
					if (cnt_q == '0) begin
						state_q <= L_SETUP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				L_SETUP: begin
					if (early_zero) begin
						state_q <= L_DONE;
					end else begin
						state_q <= L_MUL;
						cnt_q   <= CNT_W'(EXT_W - 1);
					end
				end
				L_MUL: begin
					if (cnt_q == '0) begin
						state_q <= L_SAT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				L_SAT: begin
					if (sat) begin
						state_q <= L_DONE;
					end else begin
						state_q <= L_DIV;
						cnt_q   <= CNT_W'(EXT_W - 1);
					end
				end
				L_DIV: begin
					if (cnt_q == '0) begin
						state_q <= L_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE, L_DONE: begin
				if (start) begin
					num_q <= total;
					rem_q <= '0;
				end
			end
			L_AVG: begin
				num_q <= {num_q[TOT_W-2:0], avg_ge};
				rem_q <= rem_nx;
			end
			L_SETUP: begin
				diff_q   <= avg - lower;
				den_q    <= upper - lower;
				ext_q    <= extent;
				acc_q    <= '0;
				result_q <= '0;
			end
			L_MUL: begin
				acc_q <= acc_nx;
				ext_q <= {ext_q[EXT_W-2:0], 1'b0};
			end
			L_SAT: begin
				result_q <= '1;
				rdv_q    <= acc_q[PROD_W-1:EXT_W];
				ext_q    <= acc_q[EXT_W-1:0];
			end
			L_DIV: begin
				rdv_q <= div_nx[SAMPLE_BITS-1:0];
				ext_q <= {ext_q[EXT_W-2:0], div_ge};
				if (cnt_q == '0) begin
					result_q <= {ext_q[EXT_W-2:0], div_ge};
				end
			end
			default: begin
			end
		endcase
	end

	assign result = result_q;
	assign done   = (state_q == L_DONE);

endmodule

// ===== hdl/touch_sample_filter_unit.sv =====
// Touch sample filter: windowing, debounce, moving averages and screen mapping.
// Each request updates the history; both mapping lanes then run the serial divide by the depth
// over TOT_W = SAMPLE_BITS + clog2(AVG_DEPTH) bits and the 12-step multiply and divide, ending
// early on a zero or saturated result. A new request is taken only once the previous result
// has been registered at the output.
// Reset clears status, totals, history valid bits and loads the default window.
module touch_sample_filter_unit #(
	parameter int AVG_DEPTH   = tsf_pkg::AVG_DEPTH_DEF,
	parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [SAMPLE_BITS-1:0]                 sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   touched,
	output logic [tsf_pkg::EXT_W-1:0]              screen_x,
	output logic [tsf_pkg::EXT_W-1:0]              screen_y,
	output logic                                   was_y_phase,
	input  logic                                   cfg_we,
	input  logic [tsf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [((SAMPLE_BITS > tsf_pkg::EXT_W) ?
	               SAMPLE_BITS : tsf_pkg::EXT_W)-1:0] cfg_data
);
	import tsf_pkg::*;

	localparam int TOT_W = SAMPLE_BITS + $clog2(AVG_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_UPD   = 2'd1;
	localparam logic [1:0] ST_START = 2'd2;
	localparam logic [1:0] ST_MAP   = 2'd3;

	logic [1:0]             state_q;
	logic [SAMPLE_BITS-1:0] x_lower_q;
	logic [SAMPLE_BITS-1:0] x_upper_q;
	logic [SAMPLE_BITS-1:0] y_lower_q;
	logic [SAMPLE_BITS-1:0] y_upper_q;
	logic [EXT_W-1:0]       x_extent_q;
	logic [EXT_W-1:0]       y_extent_q;
	logic                   was_y_q;
	logic                   out_valid_q;
	logic                   touched_q;
	logic [EXT_W-1:0]       screen_x_q;
	logic [EXT_W-1:0]       screen_y_q;
	logic                   was_y_out_q;

	hist_cmd_t              cmd;
	logic                   accept;
	logic                   finish;
	logic [TOT_W-1:0]       x_total;
	logic [TOT_W-1:0]       y_total;
	logic                   hist_touched;
	logic                   hist_y_phase;
	logic                   lane_start;
	logic [EXT_W-1:0]       x_result;
	logic [EXT_W-1:0]       y_result;
	logic                   x_done;
	logic                   y_done;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign cmd.rd     = accept;
	assign cmd.upd    = (state_q == ST_UPD);
	assign lane_start = (state_q == ST_START);
	// The result is held back while the previous one is still waiting.
	assign finish     = (state_q == ST_MAP) && x_done && y_done &&
	                    (!out_valid_q || out_ready);

	tsf_hist #(
		.AVG_DEPTH   (AVG_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sample  (sample),
		.x_lower (x_lower_q),
		.x_upper (x_upper_q),
		.y_lower (y_lower_q),
		.y_upper (y_upper_q),
		.x_total (x_total),
		.y_total (y_total),
		.touched (hist_touched),
		.y_phase (hist_y_phase)
	);

	tsf_map #(
		.AVG_DEPTH   (AVG_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_map_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.total  (x_total),
		.lower  (x_lower_q),
		.upper  (x_upper_q),
		.extent (x_extent_q),
		.result (x_result),
		.done   (x_done)
	);

	tsf_map #(
		.AVG_DEPTH   (AVG_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_map_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.total  (y_total),
		.lower  (y_lower_q),
		.upper  (y_upper_q),
		.extent (y_extent_q),
		.result (y_result),
		.done   (y_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lower_q  <= SAMPLE_BITS'(X_LOWER_RST);
			x_upper_q  <= SAMPLE_BITS'(X_UPPER_RST);
			y_lower_q  <= SAMPLE_BITS'(Y_LOWER_RST);
			y_upper_q  <= SAMPLE_BITS'(Y_UPPER_RST);
			x_extent_q <= EXT_W'(X_EXTENT_RST);
			y_extent_q <= EXT_W'(Y_EXTENT_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_LOWER:  x_lower_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_X_UPPER:  x_upper_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_Y_LOWER:  y_lower_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_Y_UPPER:  y_upper_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_X_EXTENT: x_extent_q <= cfg_data[EXT_W-1:0];
				REG_Y_EXTENT: y_extent_q <= cfg_data[EXT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD:   state_q <= ST_START;
				ST_START: state_q <= ST_MAP;
				ST_MAP: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			was_y_q <= hist_y_phase;
		end
		if (finish) begin
			touched_q   <= hist_touched;
			screen_x_q  <= x_result;
			screen_y_q  <= y_result;
			was_y_out_q <= was_y_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign touched     = touched_q;
	assign screen_x    = screen_x_q;
	assign screen_y    = screen_y_q;
	assign was_y_phase = was_y_out_q;

endmodule

// ===== hdl/tsf_checker.sv =====
// Port-level checks of the touch sample filter, bound to its top level.
module tsf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      touched,
	input logic [tsf_pkg::EXT_W-1:0] screen_x,
	input logic [tsf_pkg::EXT_W-1:0] screen_y,
	input logic                      was_y_phase
);
	import tsf_pkg::*;

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;
	logic       exp_y_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Requests still owed a result, and the axis the next result must carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			exp_y_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
			if (out_acc) begin
				exp_y_q <= ~exp_y_q;
			end
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request taken while the previous one is still being processed");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q == 2'd1 || pend_q == 2'd2))
		else $error("result shown without an outstanding request");

	a_phase_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (was_y_phase == exp_y_q))
		else $error("results do not alternate between X and Y, starting with X");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(touched) &&
			$stable(screen_x) && $stable(screen_y) && $stable(was_y_phase)))
		else $error("stalled result changed or was withdrawn");

endmodule

bind touch_sample_filter_unit tsf_checker u_tsf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.touched     (touched),
	.screen_x    (screen_x),
	.screen_y    (screen_y),
	.was_y_phase (was_y_phase)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the touch sample filter unit with its own predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tsf_pkg::*;

	localparam int SB          = SAMPLE_BITS_DEF;
	localparam int CFG_W       = (SB > EXT_W) ? SB : EXT_W;
	localparam int SLOT_W      = $clog2(AVG_DEPTH_DEF);
	localparam int SUM_W       = SB + SLOT_W;
	localparam int SCREEN_TOP  = 2 ** EXT_W - 1;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 120;
	localparam int DRAIN_WAIT  = 80;

	// Indexes that decode to no register; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic             touched;
		logic [EXT_W-1:0] screen_x;
		logic [EXT_W-1:0] screen_y;
		logic             was_y;
	} touch_point_t;

	class touch_track;
		logic [SB-1:0]     x_lo, x_hi, y_lo, y_hi;
		logic [EXT_W-1:0]  x_ext, y_ext;
		logic              expect_x;
		int                settle;
		logic              touch;
		logic [SB-1:0]     x_hist[AVG_DEPTH_DEF];
		logic [SB-1:0]     y_hist[AVG_DEPTH_DEF];
		logic [SUM_W-1:0]  x_sum, y_sum;
		logic [SLOT_W-1:0] slot;
		touch_point_t      pending[$];
		int                errors;

		function new();
			x_lo = SB'(X_LOWER_RST);
			x_hi = SB'(X_UPPER_RST);
			y_lo = SB'(Y_LOWER_RST);
			y_hi = SB'(Y_UPPER_RST);
			x_ext = EXT_W'(X_EXTENT_RST);
			y_ext = EXT_W'(Y_EXTENT_RST);
			expect_x = 1'b1;
			settle = 0;
			touch = 1'b0;
			foreach (x_hist[i]) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
			x_sum = '0;
			y_sum = '0;
			slot = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_X_LOWER:  x_lo = data[SB-1:0];
				REG_X_UPPER:  x_hi = data[SB-1:0];
				REG_Y_LOWER:  y_lo = data[SB-1:0];
				REG_Y_UPPER:  y_hi = data[SB-1:0];
				REG_X_EXTENT: x_ext = data[EXT_W-1:0];
				REG_Y_EXTENT: y_ext = data[EXT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [EXT_W-1:0] screen_coord(logic [SUM_W-1:0] total, logic [SB-1:0] lo,
				logic [SB-1:0] hi, logic [EXT_W-1:0] ext);
			longint unsigned avg, scaled;
			avg = total / AVG_DEPTH_DEF;
			if (hi <= lo || avg < lo)
				return '0;
			scaled = (avg - lo) * ext / (hi - lo);
			if (scaled > SCREEN_TOP)
				return EXT_W'(SCREEN_TOP);
			return scaled[EXT_W-1:0];
		endfunction

		function void take_sample(logic [SB-1:0] s);
			touch_point_t p;
			logic [SB-1:0] v;
			logic was_y;
			v = s;
			was_y = !expect_x;
			if (expect_x) begin
				expect_x = 1'b0;
				if (v < x_lo || v > x_hi) begin
					v = x_lo;
					touch = 1'b0;
					settle = 0;
				end else begin
					settle++;
				end
				if (settle >= AVG_DEPTH_DEF) begin
					settle = 0;
					touch = 1'b1;
				end
				x_sum = x_sum - x_hist[slot] + v;
				x_hist[slot] = v;
			end else begin
				expect_x = 1'b1;
				if (v < y_lo || v > y_hi) begin
					v = y_lo;
					touch = 1'b0;
				end
				y_sum = y_sum - y_hist[slot] + v;
				y_hist[slot] = v;
				slot = slot + 1'b1;
			end
			p.touched = touch;
			p.screen_x = screen_coord(x_sum, x_lo, x_hi, x_ext);
			p.screen_y = screen_coord(y_sum, y_lo, y_hi, y_ext);
			p.was_y = was_y;
			pending.push_back(p);
		endfunction

		function void compare_point(logic t, logic [EXT_W-1:0] sx, logic [EXT_W-1:0] sy,
				logic wy);
			touch_point_t want;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: touched %0d screen_x %0d screen_y %0d",
					t, sx, sy);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (want.touched !== t) begin
				$error("touched: expected %0d, actual %0d", want.touched, t);
				errors++;
			end
			if (want.screen_x !== sx) begin
				$error("screen_x: expected %0d, actual %0d", want.screen_x, sx);
				errors++;
			end
			if (want.screen_y !== sy) begin
				$error("screen_y: expected %0d, actual %0d", want.screen_y, sy);
				errors++;
			end
			if (want.was_y !== wy) begin
				$error("was_y_phase: expected %0d, actual %0d", want.was_y, wy);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [SB-1:0]        sample;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 touched;
	logic [EXT_W-1:0]     screen_x;
	logic [EXT_W-1:0]     screen_y;
	logic                 was_y_phase;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	logic sender_gaps = 1'b1;
	logic sink_stalls = 1'b1;
	int   quiet = 0;

	touch_track track = new();

	touch_sample_filter_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.touched     (touched),
		.screen_x    (screen_x),
		.screen_y    (screen_y),
		.was_y_phase (was_y_phase),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	// Both handshakes are observed here; the watchdog restarts on any handshake or configuration write.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				track.take_sample(sample);
			if (out_valid && out_ready)
				track.compare_point(touched, screen_x, screen_y, was_y_phase);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				if (sink_stalls && $urandom_range(0, 24) == 0)
					hold = $urandom_range(1, 16);
			end
		end
	end

	task automatic send_sample(logic [SB-1:0] s);
		if (sender_gaps && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (track.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		track.write_reg(idx, data);
	endtask

	task automatic apply_window(logic [CFG_W-1:0] xl, logic [CFG_W-1:0] xu,
			logic [CFG_W-1:0] yl, logic [CFG_W-1:0] yu,
			logic [CFG_W-1:0] xe, logic [CFG_W-1:0] ye);
		put_reg(REG_X_LOWER, xl);
		put_reg(REG_SPARE_A, CFG_W'($urandom_range(0, SCREEN_TOP)));
		put_reg(REG_X_UPPER, xu);
		put_reg(REG_Y_LOWER, yl);
		put_reg(REG_Y_UPPER, yu);
		put_reg(REG_X_EXTENT, xe);
		put_reg(REG_SPARE_B, CFG_W'($urandom_range(0, SCREEN_TOP)));
		put_reg(REG_Y_EXTENT, ye);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SB-1:0] pick_in(logic [SB-1:0] lo, logic [SB-1:0] hi);
		if (lo <= hi)
			return SB'($urandom_range(hi, lo));
		return SB'($urandom_range(2 ** SB - 1, 0));
	endfunction

	// Values on or just outside the window edges; the outside ones wrap at the range ends.
	function automatic logic [SB-1:0] pick_bound(logic [SB-1:0] lo, logic [SB-1:0] hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			2: return lo - 1'b1;
			default: return hi + 1'b1;
		endcase
	endfunction

	// Mostly well-formed touches (runs of in-window X and Y pairs), some noise and some
	// runs broken by a single sample on or past an edge.
	task automatic run_samples(int n);
		int sent, mode, k, broken;
		logic [SB-1:0] xs, ys;
		sent = 0;
		while (sent < n) begin
			mode = $urandom_range(0, 9);
			k = (mode < 7) ? $urandom_range(1, 20) : $urandom_range(1, 6);
			broken = $urandom_range(0, 2 * k - 1);
			for (int j = 0; j < k; j++) begin
				if (mode == 7 || mode == 8) begin
					xs = SB'($urandom_range(2 ** SB - 1, 0));
					ys = SB'($urandom_range(2 ** SB - 1, 0));
				end else begin
					xs = ($urandom_range(0, 15) == 0) ? pick_bound(track.x_lo, track.x_hi)
						: pick_in(track.x_lo, track.x_hi);
					ys = ($urandom_range(0, 15) == 0) ? pick_bound(track.y_lo, track.y_hi)
						: pick_in(track.y_lo, track.y_hi);
					if (mode == 9 && broken == 2 * j)
						xs = pick_bound(track.x_lo, track.x_hi);
					if (mode == 9 && broken == 2 * j + 1)
						ys = pick_bound(track.y_lo, track.y_hi);
				end
				send_sample(xs);
				send_sample(ys);
				sent += 2;
			end
		end
		drain();
	endtask

	initial begin
		logic [SB-1:0] opening[26];
		logic [CFG_W-1:0] xl, xu, yl, yu, xe, ye;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		// Range ends, window edges on both sides, then enough in-window pairs to settle.
		opening = '{10'd0, 10'd1023, 10'd119, 10'd926, 10'd120, 10'd120, 10'd875, 10'd925,
			10'd876, 10'd119, 10'd300, 10'd400, 10'd310, 10'd410, 10'd320, 10'd420,
			10'd330, 10'd430, 10'd340, 10'd440, 10'd350, 10'd450, 10'd360, 10'd460,
			10'd370, 10'd470};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening[i])
			send_sample(opening[i]);
		drain();

		for (int p = 0; p < 9; p++) begin
			xl = CFG_W'($urandom_range(0, 511));
			xu = CFG_W'($urandom_range(1023, xl));
			yl = CFG_W'($urandom_range(0, 511));
			yu = CFG_W'($urandom_range(1023, yl));
			xe = CFG_W'($urandom_range(1, SCREEN_TOP));
			ye = CFG_W'($urandom_range(1, SCREEN_TOP));
			case (p)
				1: begin
					xl = '0; xu = CFG_W'(1023); yl = '0; yu = CFG_W'(1023);
					xe = CFG_W'(SCREEN_TOP); ye = CFG_W'(SCREEN_TOP);
				end
				// A narrow window after wide history drives the map into saturation.
				2: begin
					xl = '0; xu = CFG_W'(3); yl = CFG_W'(10); yu = CFG_W'(12);
					xe = CFG_W'(SCREEN_TOP); ye = CFG_W'(SCREEN_TOP);
				end
				3: begin
					xl = CFG_W'(500); xu = CFG_W'(500); yl = CFG_W'(900); yu = CFG_W'(100);
					xe = '0; ye = CFG_W'(1);
				end
				4: begin
					xl = CFG_W'(1023); xu = '0; yl = '0; yu = CFG_W'(1023);
					xe = CFG_W'(SCREEN_TOP); ye = '0;
				end
				5, 6, 7: begin
					if ($urandom_range(0, 3) == 0) xl = CFG_W'($urandom_range(0, SCREEN_TOP));
					if ($urandom_range(0, 3) == 0) xu = CFG_W'($urandom_range(0, SCREEN_TOP));
					if ($urandom_range(0, 3) == 0) yl = CFG_W'($urandom_range(0, SCREEN_TOP));
					if ($urandom_range(0, 3) == 0) yu = CFG_W'($urandom_range(0, SCREEN_TOP));
					if ($urandom_range(0, 7) == 0) xe = '0;
				end
				8: begin
					xl = CFG_W'(X_LOWER_RST); xu = CFG_W'(X_UPPER_RST);
					yl = CFG_W'(Y_LOWER_RST); yu = CFG_W'(Y_UPPER_RST);
					xe = CFG_W'(X_EXTENT_RST); ye = CFG_W'(Y_EXTENT_RST);
				end
				default: ;
			endcase
			sender_gaps = (p != 1 && p != 8);
			sink_stalls = (p != 1 && p != 8);
			apply_window(xl, xu, yl, yu, xe, ye);
			run_samples(PHASE_ITEMS);
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (track.errors == 0 && track.outstanding() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== touch_sample_filter_unit.f =====
hdl/tsf_pkg.sv
hdl/tsf_hist.sv
hdl/tsf_map.sv
hdl/touch_sample_filter_unit.sv
hdl/tsf_checker.sv
tb/sv/tb_top.sv
